// ===== rtl/nst_pkg.sv =====
// ----------------------------------------------------------------------------
// nst_pkg
// Shared types, constants and helpers of the named counting semaphore table.
// ----------------------------------------------------------------------------
package nst_pkg;

	localparam int SLOTS      = 16;
	localparam int NAME_BYTES = 8;

	localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NAME_W   = 64;
	localparam int LABEL_W  = 8 * NAME_BYTES;
	localparam int COUNT_W  = 16;
	localparam int HANDLE_W = 4;
	localparam int CALLER_W = 8;

	localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
	localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};

	typedef enum logic [1:0] {
		MODE_CREATE  = 2'd0,
		MODE_WAIT    = 2'd1,
		MODE_SIGNAL  = 2'd2,
		MODE_DESTROY = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT,
		ST_RDCNT,
		ST_UPDATE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [CALLER_W-1:0]       caller_id;
		logic [HANDLE_W-1:0]       slot_handle;
		logic signed [COUNT_W-1:0] init_count;
		logic [NAME_W-1:0]         sem_name;
		mode_t                     mode;
	} req_t;

	typedef struct packed {
		logic                wake_one;
		logic                must_block;
		logic [HANDLE_W-1:0] result_handle;
		logic                status;
	} res_t;

	typedef struct packed {
		logic                      ok;
		logic                      must_block;
		logic                      wake_one;
		logic signed [COUNT_W-1:0] count;
	} cu_res_t;

	typedef struct packed {
		logic               we;
		logic [SLOT_W-1:0]  addr;
		logic [LABEL_W-1:0] data;
	} lbl_wr_t;

	typedef struct packed {
		logic                      we;
		logic [SLOT_W-1:0]         addr;
		logic signed [COUNT_W-1:0] data;
	} cnt_wr_t;

	function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] raw);
		logic              keep;
		logic [NAME_W-1:0] nm;
		keep = 1'b1;
		nm   = '0;
		for (int b = 0; b < NAME_BYTES; b++) begin
			if (raw[8*b +: 8] == 8'h00) begin
				keep = 1'b0;
			end
			if (keep) begin
				nm[8*b +: 8] = raw[8*b +: 8];
			end
		end
		return nm;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_of(input logic [HANDLE_W-1:0] h);
		return SLOT_W'(h);
	endfunction

endpackage

// ===== rtl/nst_ram.sv =====
// ----------------------------------------------------------------------------
// nst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/nst_cnt_unit.sv =====
// ----------------------------------------------------------------------------
// nst_cnt_unit
// Saturating count update for P and V, with wait and wake flags, and the destroy check.
// ----------------------------------------------------------------------------
module nst_cnt_unit (
	input  nst_pkg::mode_t                      op,
	input  logic signed [nst_pkg::COUNT_W-1:0]  count_in,
	output nst_pkg::cu_res_t                    res
);

	always_comb begin
		res.ok         = 1'b1;
		res.must_block = 1'b0;
		res.wake_one   = 1'b0;
		res.count      = count_in;
		case (op)
			nst_pkg::MODE_WAIT: begin
				if (count_in != nst_pkg::COUNT_MIN) begin
					res.count = count_in - 1'b1;
				end
				res.must_block = res.count[nst_pkg::COUNT_W-1];
			end
			nst_pkg::MODE_SIGNAL: begin
				if (count_in != nst_pkg::COUNT_MAX) begin
					res.count = count_in + 1'b1;
				end
				res.wake_one = res.count[nst_pkg::COUNT_W-1] || (res.count == '0);
			end
			nst_pkg::MODE_DESTROY: begin
				res.ok = !count_in[nst_pkg::COUNT_W-1];
			end
			default: begin
				res.ok = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/nst_seq.sv =====
// ----------------------------------------------------------------------------
// nst_seq
// Sequencer: name scan over the label store, count update, result register.
// ----------------------------------------------------------------------------
module nst_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  nst_pkg::req_t                    in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output nst_pkg::res_t                    out_item,
	output logic [nst_pkg::SLOT_W-1:0]       lbl_raddr,
	input  logic [nst_pkg::LABEL_W-1:0]      lbl_rdata,
	output nst_pkg::lbl_wr_t                 lbl_wr,
	output logic [nst_pkg::SLOT_W-1:0]       cnt_raddr,
	input  logic signed [nst_pkg::COUNT_W-1:0] cnt_rdata,
	output nst_pkg::cnt_wr_t                 cnt_wr
);

	localparam logic [nst_pkg::SLOT_W:0]   SCAN_END  = (nst_pkg::SLOT_W+1)'(nst_pkg::SLOTS);
	localparam logic [nst_pkg::SLOT_W-1:0] SLOT_LAST = nst_pkg::SLOT_W'(nst_pkg::SLOTS - 1);

	nst_pkg::state_t                 state_q, state_d;
	nst_pkg::req_t                   req_q;
	nst_pkg::res_t                   res_q, out_res_q;
	nst_pkg::cu_res_t                cu_res;
	logic [nst_pkg::SLOTS-1:0]       used_q;
	logic [nst_pkg::SLOT_W:0]        cnt_q;
	logic [nst_pkg::SLOT_W-1:0]      chk_idx_s1, pick_q, req_slot, in_slot;
	logic                            chk_vld_s1, have_free_q, taken_q, found_q;
	logic                            out_valid_q, accept, out_load, scan_issue;
	logic                            is_create, hit, create_ok, in_ok;

	nst_cnt_unit u_cnt_unit (
		.op       (req_q.mode),
		.count_in (cnt_rdata),
		.res      (cu_res)
	);

	assign in_slot   = nst_pkg::slot_of(in_item.slot_handle);
	assign req_slot  = nst_pkg::slot_of(req_q.slot_handle);
	assign in_ok     = (32'(in_item.slot_handle) < nst_pkg::SLOTS) && used_q[in_slot];
	assign is_create = (req_q.mode == nst_pkg::MODE_CREATE) &&
	                   !req_q.init_count[nst_pkg::COUNT_W-1];
	assign hit       = used_q[chk_idx_s1] &&
	                   (lbl_rdata == req_q.sem_name[nst_pkg::LABEL_W-1:0]);
	assign create_ok = have_free_q && !taken_q;
	assign accept    = in_valid && in_ready;
	assign out_load  = (state_q == nst_pkg::ST_OUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_res_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			nst_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_item.mode == nst_pkg::MODE_CREATE) begin
						state_d = nst_pkg::ST_SCAN;
					end else if (in_ok) begin
						state_d = nst_pkg::ST_RDCNT;
					end else begin
						state_d = nst_pkg::ST_OUT;
					end
				end
			end
			nst_pkg::ST_SCAN: begin
				if (chk_vld_s1 && (chk_idx_s1 == SLOT_LAST)) begin
					state_d = nst_pkg::ST_COMMIT;
				end
			end
			nst_pkg::ST_COMMIT: state_d = nst_pkg::ST_OUT;
			nst_pkg::ST_RDCNT:  state_d = nst_pkg::ST_UPDATE;
			nst_pkg::ST_UPDATE: state_d = nst_pkg::ST_OUT;
			nst_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = nst_pkg::ST_IDLE;
				end
			end
			default: state_d = nst_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == nst_pkg::ST_IDLE);
		scan_issue   = (state_q == nst_pkg::ST_SCAN) && (cnt_q < SCAN_END);
		lbl_raddr    = cnt_q[nst_pkg::SLOT_W-1:0];
		cnt_raddr    = req_slot;
		lbl_wr.we    = (state_q == nst_pkg::ST_COMMIT) && is_create && create_ok;
		lbl_wr.addr  = pick_q;
		lbl_wr.data  = req_q.sem_name[nst_pkg::LABEL_W-1:0];
		cnt_wr.we    = lbl_wr.we;
		cnt_wr.addr  = pick_q;
		cnt_wr.data  = req_q.init_count;
		if ((state_q == nst_pkg::ST_UPDATE) && (req_q.mode != nst_pkg::MODE_DESTROY)) begin
			cnt_wr.we   = 1'b1;
			cnt_wr.addr = req_slot;
			cnt_wr.data = cu_res.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nst_pkg::ST_IDLE;
			used_q      <= '0;
			chk_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= scan_issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (lbl_wr.we) begin
				used_q[pick_q] <= 1'b1;
			end
			if ((state_q == nst_pkg::ST_UPDATE) && (req_q.mode == nst_pkg::MODE_DESTROY) &&
			    cu_res.ok) begin
				used_q[req_slot] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= lbl_raddr;
		case (state_q)
			nst_pkg::ST_IDLE: begin
				if (accept) begin
					req_q.mode        <= in_item.mode;
					req_q.sem_name    <= nst_pkg::norm_name(in_item.sem_name);
					req_q.init_count  <= in_item.init_count;
					req_q.slot_handle <= in_item.slot_handle;
					req_q.caller_id   <= in_item.caller_id;
					cnt_q             <= '0;
					have_free_q       <= 1'b0;
					taken_q           <= 1'b0;
					found_q           <= 1'b0;
					pick_q            <= '0;
					res_q             <= '{wake_one: 1'b0, must_block: 1'b0,
					                       result_handle: '0, status: 1'b1};
				end
			end
			nst_pkg::ST_SCAN: begin
				if (scan_issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (chk_vld_s1) begin
					if (is_create) begin
						if (!used_q[chk_idx_s1]) begin
							have_free_q <= 1'b1;
							pick_q      <= chk_idx_s1;
						end else if (hit) begin
							taken_q <= 1'b1;
						end
					end else if (hit && !found_q) begin
						found_q <= 1'b1;
						pick_q  <= chk_idx_s1;
					end
				end
			end
			nst_pkg::ST_COMMIT: begin
				if (is_create ? create_ok : found_q) begin
					res_q.status        <= 1'b0;
					res_q.result_handle <= nst_pkg::HANDLE_W'(pick_q);
				end
			end
			nst_pkg::ST_UPDATE: begin
				res_q.status     <= !cu_res.ok;
				res_q.must_block <= cu_res.must_block;
				res_q.wake_one   <= cu_res.wake_one;
			end
			nst_pkg::ST_OUT: begin
				if (out_load) begin
					out_res_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_create_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		lbl_wr.we |-> !used_q[lbl_wr.addr])
		else $error("create writes an occupied slot");

	a_update_used_slot: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == nst_pkg::ST_UPDATE) && cnt_wr.we) |-> used_q[cnt_wr.addr])
		else $error("count update on a free slot");

	a_update_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nst_pkg::ST_UPDATE) |-> ($past(state_q) == nst_pkg::ST_RDCNT))
		else $error("count update without a count read");

	a_compare_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> (state_q == nst_pkg::ST_SCAN))
		else $error("name compare outside of a scan");
`endif

endmodule

// ===== rtl/named_counting_semaphore_table_top.sv =====
// ----------------------------------------------------------------------------
// named_counting_semaphore_table_top
// Table of named counting semaphores with create, open, P, V and destroy.
// ----------------------------------------------------------------------------
// One request item enters on the s_axis channel and gives exactly one result
// item on the m_axis channel. The block takes one item at a time.
// Create and open walk every slot through the label RAM, one slot per cycle,
// and then commit; the block returns to idle as it loads the result into the
// output register and takes the next item from there. P and V read and write
// the count RAM once; destroy only reads it. A handle beyond the table or a
// free slot fails without a count RAM access.
// The result sits in an output register, so a new item is accepted while the
// previous result still waits; a further result waits inside the block until
// the receiver takes the first one, and s_axis_tready stays low meanwhile.
// Reset frees every slot at once through the occupancy flags; the label and
// count RAMs need no clearing pass and the block is ready right after reset.
// ----------------------------------------------------------------------------
module named_counting_semaphore_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[1:0], sem_name[65:2], init_count[81:66], slot_handle[85:82],
	// caller_id[93:86], zero[95:94]
	input  logic [95:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[0], result_handle[4:1], must_block[5], wake_one[6], zero[7]
	output logic [7:0]  m_axis_tdata
);

	nst_pkg::req_t                         req;
	nst_pkg::res_t                         res;
	nst_pkg::lbl_wr_t                      lbl_wr;
	nst_pkg::cnt_wr_t                      cnt_wr;
	logic [nst_pkg::SLOT_W-1:0]            lbl_raddr, cnt_raddr;
	logic [nst_pkg::LABEL_W-1:0]           lbl_rdata;
	logic signed [nst_pkg::COUNT_W-1:0]    cnt_rdata;

	assign req.mode        = nst_pkg::mode_t'(s_axis_tdata[1:0]);
	assign req.sem_name    = s_axis_tdata[65:2];
	assign req.init_count  = s_axis_tdata[81:66];
	assign req.slot_handle = s_axis_tdata[85:82];
	assign req.caller_id   = s_axis_tdata[93:86];

	assign m_axis_tdata = {1'b0, res.wake_one, res.must_block, res.result_handle, res.status};

	nst_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (req),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (res),
		.lbl_raddr (lbl_raddr),
		.lbl_rdata (lbl_rdata),
		.lbl_wr    (lbl_wr),
		.cnt_raddr (cnt_raddr),
		.cnt_rdata (cnt_rdata),
		.cnt_wr    (cnt_wr)
	);

	nst_ram #(
		.WIDTH (nst_pkg::LABEL_W),
		.DEPTH (nst_pkg::SLOTS)
	) u_label_ram (
		.clk   (clk),
		.we    (lbl_wr.we),
		.waddr (lbl_wr.addr),
		.wdata (lbl_wr.data),
		.raddr (lbl_raddr),
		.rdata (lbl_rdata)
	);

	nst_ram #(
		.WIDTH (nst_pkg::COUNT_W),
		.DEPTH (nst_pkg::SLOTS)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_wr.we),
		.waddr (cnt_wr.addr),
		.wdata (cnt_wr.data),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the named counting semaphore table end to end. Requests go in on the
// s_axis side with random gaps and come back one result each on the m_axis
// side under random backpressure. A scoreboard keeps its own copy of the
// slot table, predicts every result and compares it field by field. A
// directed opening covers the edge cases. Random episodes with varying
// create pressure fill and drain the table. A short closing run of waits,
// signals and destroys works on one busy slot.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	class semaphore_scoreboard;
		bit                busy[nst_pkg::SLOTS];
		logic [63:0]       tag[nst_pkg::SLOTS];
		logic signed [15:0] level[nst_pkg::SLOTS];
		logic [7:0]        owner[nst_pkg::SLOTS];
		nst_pkg::res_t     replies_due[$];
		int                bad_replies;

		function new();
			for (int i = 0; i < nst_pkg::SLOTS; i++) begin
				busy[i] = 1'b0;
				tag[i]  = '0;
			end
			bad_replies = 0;
		endfunction

		function logic [63:0] trim_name(logic [63:0] raw);
			int len;
			len = nst_pkg::NAME_BYTES;
			for (int b = nst_pkg::NAME_BYTES - 1; b >= 0; b--) begin
				if (raw[8*b +: 8] == 8'h00)
					len = b;
			end
			if (len == 0)
				return '0;
			return raw & ({64{1'b1}} >> (64 - 8 * len));
		endfunction

		function void predict_reply(nst_pkg::req_t r);
			nst_pkg::res_t e;
			logic [63:0]   nm;
			logic [3:0]    h;
			bit            have_free;
			bit            taken;
			int            pick;
			e         = '0;
			e.status  = 1'b1;
			nm        = trim_name(r.sem_name);
			h         = r.slot_handle;
			have_free = 1'b0;
			taken     = 1'b0;
			pick      = 0;
			if (r.mode == nst_pkg::MODE_CREATE) begin
				if (r.init_count >= 0) begin
					for (int i = 0; i < nst_pkg::SLOTS; i++) begin
						if (!busy[i]) begin
							have_free = 1'b1;
							pick      = i;
						end else if (tag[i] == nm) begin
							taken = 1'b1;
						end
					end
					if (have_free && !taken) begin
						busy[pick]      = 1'b1;
						tag[pick]       = nm;
						owner[pick]     = r.caller_id;
						level[pick]     = r.init_count;
						e.status        = 1'b0;
						e.result_handle = 4'(pick);
					end
				end else begin
					for (int i = nst_pkg::SLOTS - 1; i >= 0; i--) begin
						if (busy[i] && tag[i] == nm) begin
							taken = 1'b1;
							pick  = i;
						end
					end
					if (taken) begin
						e.status        = 1'b0;
						e.result_handle = 4'(pick);
					end
				end
			end else if (int'(h) < nst_pkg::SLOTS && busy[h]) begin
				case (r.mode)
					nst_pkg::MODE_WAIT: begin
						if (level[h] != nst_pkg::COUNT_MIN)
							level[h] = level[h] - 16'sd1;
						e.must_block = (level[h] < 0);
						e.status     = 1'b0;
					end
					nst_pkg::MODE_SIGNAL: begin
						if (level[h] != nst_pkg::COUNT_MAX)
							level[h] = level[h] + 16'sd1;
						e.wake_one = (level[h] <= 0);
						e.status   = 1'b0;
					end
					default: begin
						if (level[h] >= 0) begin
							busy[h]  = 1'b0;
							tag[h]   = '0;
							e.status = 1'b0;
						end
					end
				endcase
			end
			replies_due.push_back(e);
		endfunction

		function void check_reply(nst_pkg::res_t got);
			nst_pkg::res_t exp;
			if (replies_due.size() == 0) begin
				bad_replies++;
				if (bad_replies <= 10)
					$display("%0t: unexpected result %b", $time, got);
				return;
			end
			exp = replies_due.pop_front();
			if (got.status !== exp.status || got.result_handle !== exp.result_handle ||
			    got.must_block !== exp.must_block || got.wake_one !== exp.wake_one) begin
				bad_replies++;
				if (bad_replies <= 10) begin
					$display("%0t: expected status=%0b handle=%0d block=%0b wake=%0b",
					         $time, exp.status, exp.result_handle, exp.must_block,
					         exp.wake_one);
					$display("%0t: actual   status=%0b handle=%0d block=%0b wake=%0b",
					         $time, got.status, got.result_handle, got.must_block,
					         got.wake_one);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;

	semaphore_scoreboard sb;
	bit                  idle_on = 1'b1;
	int                  stall_left = 0;
	logic [63:0]         name_pool[24];
	int                  name_len[24];

	named_counting_semaphore_table_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic nst_pkg::req_t make_req(nst_pkg::mode_t m, logic [63:0] nm,
	                                           logic signed [15:0] init,
	                                           logic [3:0] h, logic [7:0] who);
		nst_pkg::req_t r;
		r.mode        = m;
		r.sem_name    = nm;
		r.init_count  = init;
		r.slot_handle = h;
		r.caller_id   = who;
		return r;
	endfunction

	task automatic issue(input nst_pkg::req_t r);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, r};
		do @(posedge clk); while (!s_axis_tready);
		sb.predict_reply(r);
	endtask

	task automatic random_item(input int create_pct);
		nst_pkg::req_t r;
		int            roll;
		int            k;
		int            live[$];
		logic [63:0]   raw;
		roll          = $urandom_range(0, 99);
		r.sem_name    = {$urandom, $urandom};
		r.init_count  = 16'($urandom);
		r.slot_handle = 4'($urandom);
		r.caller_id   = 8'($urandom);
		if (roll < create_pct) begin
			r.mode = nst_pkg::MODE_CREATE;
			if ($urandom_range(0, 6) != 0) begin
				k   = $urandom_range(0, 23);
				raw = name_pool[k];
				if (name_len[k] < 8 && $urandom_range(0, 1) == 1)
					raw = raw | ({$urandom, $urandom} << (8 * (name_len[k] + 1)));
				r.sem_name = raw;
			end
			if ($urandom_range(0, 1) == 1) begin
				case ($urandom_range(0, 5))
					0, 1, 2: r.init_count = 16'($urandom_range(0, 3));
					3:       r.init_count = nst_pkg::COUNT_MAX;
					default: r.init_count[15] = 1'b0;
				endcase
			end else begin
				case ($urandom_range(0, 3))
					0:       r.init_count = -16'sd1;
					1:       r.init_count = nst_pkg::COUNT_MIN;
					default: r.init_count[15] = 1'b1;
				endcase
			end
		end else begin
			k = (roll - create_pct) * 5 / (100 - create_pct);
			if (k < 2)
				r.mode = nst_pkg::MODE_WAIT;
			else if (k < 4)
				r.mode = nst_pkg::MODE_SIGNAL;
			else
				r.mode = nst_pkg::MODE_DESTROY;
			for (int i = 0; i < nst_pkg::SLOTS; i++) begin
				if (sb.busy[i])
					live.push_back(i);
			end
			if (live.size() != 0 && $urandom_range(0, 6) != 0)
				r.slot_handle = 4'(live[$urandom_range(0, live.size() - 1)]);
		end
		issue(r);
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_reply(nst_pkg::res_t'(m_axis_tdata[6:0]));
		if (stall_left > 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left    <= $urandom_range(0, 9);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int pct;
		int tgt;
		sb = new();
		for (int k = 0; k < 24; k++) begin
			name_len[k]  = k % 9;
			name_pool[k] = '0;
			for (int b = 0; b < name_len[k]; b++)
				name_pool[k][8*b +: 8] = 8'($urandom_range(1, 255));
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		issue(make_req(nst_pkg::MODE_CREATE,  64'h41,                  -16'sd1,
		               4'hF, 8'h01));
		issue(make_req(nst_pkg::MODE_CREATE,  64'hFFFF_FFFF_FFFF_FF00, nst_pkg::COUNT_MIN,
		               4'h0, 8'h02));
		issue(make_req(nst_pkg::MODE_CREATE,  64'hFFFF_FFFF_FFFF_FF00, 16'sd0,
		               4'h0, 8'hFF));
		issue(make_req(nst_pkg::MODE_CREATE,  64'h0,                   nst_pkg::COUNT_MAX,
		               4'hF, 8'h00));
		issue(make_req(nst_pkg::MODE_CREATE,  64'h0,                   nst_pkg::COUNT_MIN,
		               4'h5, 8'h03));
		issue(make_req(nst_pkg::MODE_CREATE,  64'hFFFF_FFFF_FFFF_FFFF, nst_pkg::COUNT_MAX,
		               4'h0, 8'h00));
		issue(make_req(nst_pkg::MODE_SIGNAL,  64'h0,                   16'sd0,
		               4'hE, 8'h04));
		issue(make_req(nst_pkg::MODE_CREATE,  64'h5A00_0000_0000_0041, 16'sd0,
		               4'h0, 8'h5A));
		issue(make_req(nst_pkg::MODE_CREATE,  64'h41,                  16'sd1,
		               4'h0, 8'h05));
		issue(make_req(nst_pkg::MODE_CREATE,  64'h7700_0000_0000_0041, -16'sd1,
		               4'h0, 8'h06));
		issue(make_req(nst_pkg::MODE_WAIT,    64'h0, 16'sd0, 4'hD, 8'h07));
		issue(make_req(nst_pkg::MODE_DESTROY, 64'h0, 16'sd0, 4'hD, 8'h08));
		issue(make_req(nst_pkg::MODE_SIGNAL,  64'h0, 16'sd0, 4'hD, 8'h09));
		issue(make_req(nst_pkg::MODE_SIGNAL,  64'h0, 16'sd0, 4'hD, 8'h0A));
		issue(make_req(nst_pkg::MODE_DESTROY, 64'h0, 16'sd0, 4'hD, 8'h0B));
		issue(make_req(nst_pkg::MODE_WAIT,    64'h0, 16'sd0, 4'hD, 8'h0C));
		issue(make_req(nst_pkg::MODE_SIGNAL,  64'h0, 16'sd0, 4'h0, 8'h0D));
		issue(make_req(nst_pkg::MODE_DESTROY, 64'h0, 16'sd0, 4'h0, 8'h0E));
		issue(make_req(nst_pkg::MODE_CREATE,  64'h42, 16'sd0, 4'h0, 8'h80));
		issue(make_req(nst_pkg::MODE_WAIT,    64'h0, 16'sd0, 4'hF, 8'h10));
		issue(make_req(nst_pkg::MODE_DESTROY, 64'h0, 16'sd0, 4'hF, 8'h11));
		issue(make_req(nst_pkg::MODE_SIGNAL,  64'h0, 16'sd0, 4'hF, 8'h12));
		issue(make_req(nst_pkg::MODE_DESTROY, 64'h0, 16'sd0, 4'hF, 8'h13));
		issue(make_req(nst_pkg::MODE_DESTROY, 64'h0, 16'sd0, 4'hE, 8'h14));

		for (int ep = 0; ep < 17; ep++) begin
			case ($urandom_range(0, 2))
				0:       pct = 25;
				1:       pct = 45;
				default: pct = 75;
			endcase
			idle_on = ($urandom_range(0, 3) != 0);
			repeat (50) random_item(pct);
		end

		// work the lowest-count busy slot; an empty table allocates its top slot
		idle_on = 1'b0;
		tgt     = -1;
		for (int i = 0; i < nst_pkg::SLOTS; i++) begin
			if (sb.busy[i] && (tgt < 0 || sb.level[i] < sb.level[tgt]))
				tgt = i;
		end
		if (tgt < 0) begin
			issue(make_req(nst_pkg::MODE_CREATE, name_pool[1], 16'sd0, 4'h0, 8'h21));
			tgt = nst_pkg::SLOTS - 1;
		end
		issue(make_req(nst_pkg::MODE_WAIT,    64'h0, 16'sd0, 4'(tgt), 8'h31));
		issue(make_req(nst_pkg::MODE_WAIT,    64'h0, 16'sd0, 4'(tgt), 8'h32));
		issue(make_req(nst_pkg::MODE_DESTROY, 64'h0, 16'sd0, 4'(tgt), 8'h33));
		issue(make_req(nst_pkg::MODE_SIGNAL,  64'h0, 16'sd0, 4'(tgt), 8'h34));
		issue(make_req(nst_pkg::MODE_DESTROY, 64'h0, 16'sd0, 4'(tgt), 8'h35));

		s_axis_tvalid <= 1'b0;
		while (sb.replies_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.bad_replies == 0 && sb.replies_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
